@@ rtl/tdrs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdrs_pkg
// Shared types, widths and constants for the tank drive ramp shaper.
// ----------------------------------------------------------------------------
package tdrs_pkg;

  localparam int STICK_W  = 16;
  localparam int TRAVEL_W = 32;
  localparam int TGT_W    = STICK_W + 1;   // negated stick, holds +32768
  localparam int CFG_W    = 15;
  localparam int SLOPE_W  = 16;
  localparam int RAMP_W   = 16;
  localparam int MAG_W    = 15;
  localparam int PROD_W   = MAG_W + SLOPE_W;
  localparam int BASEA_W  = CFG_W + SLOPE_W;
  localparam int BASEB_W  = 33;
  localparam int BASE_W   = 34;
  localparam int Y_W      = 36;
  localparam int CURVE_W  = 25;
  localparam int DIFF_W   = TRAVEL_W + 1;
  localparam int CPROD_W  = DIFF_W + 16;
  localparam int CORR_W   = 28;
  localparam int DRIVE_W  = 16;

  localparam int RAMP_LIMIT  = 20480;
  localparam int DRIVE_LIMIT = 16384;
  localparam int CORR_LIMIT  = 1 << 26;

  localparam int FIFO_DEPTH = 8;

  localparam int CFG_AW     = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_W-1:0]   MATCH_TOL_RST  = 15'd4096;
  localparam logic [CFG_W-1:0]   RAMP_STEP_RST  = 15'd328;
  localparam logic [CFG_W-1:0]   FOLLOW_GAIN_RST = 15'd328;
  localparam logic [CFG_W-1:0]   KNEE_LOW_RST   = 15'd819;
  localparam logic [CFG_W-1:0]   KNEE_HIGH_RST  = 15'd15729;
  localparam logic [SLOPE_W-1:0] SLOPE_LOW_RST  = 16'd28672;
  localparam logic [SLOPE_W-1:0] SLOPE_MID_RST  = 16'd1575;
  localparam logic [SLOPE_W-1:0] SLOPE_HIGH_RST = 16'd30720;

  typedef enum logic [2:0] {
    REG_MATCH_TOL   = 3'd0,
    REG_RAMP_STEP   = 3'd1,
    REG_FOLLOW_GAIN = 3'd2,
    REG_KNEE_LOW    = 3'd3,
    REG_KNEE_HIGH   = 3'd4,
    REG_SLOPE_LOW   = 3'd5,
    REG_SLOPE_MID   = 3'd6,
    REG_SLOPE_HIGH  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]          knee_low;
    logic [CFG_W-1:0]          knee_high;
    logic [SLOPE_W-1:0]        slope_low;
    logic [SLOPE_W-1:0]        slope_mid;
    logic [SLOPE_W-1:0]        slope_high;
    logic [BASEA_W-1:0]        base_a;   // knee_low * slope_low
    logic signed [BASEB_W-1:0] base_b;   // (knee_high - knee_low) * slope_mid
  } curve_cfg_t;

  typedef struct packed {
    logic acc;
    logic stop;
    logic apply;
    logic lpos;
  } fe_ctl_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
  } drive_pair_t;

endpackage
`default_nettype wire

@@ rtl/tdrs_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdrs_ifs
// Valid/ready channels for stick beats in and drive beats out.
// ----------------------------------------------------------------------------
interface tdrs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tdrs_pkg::STICK_W-1:0]    left_stick;
  logic signed [tdrs_pkg::STICK_W-1:0]    right_stick;
  logic                                   match_enable;
  logic                                   stop_now;
  logic signed [tdrs_pkg::TRAVEL_W-1:0]   left_travel;
  logic signed [tdrs_pkg::TRAVEL_W-1:0]   right_travel;

  modport source (output valid, left_stick, right_stick, match_enable, stop_now,
                  left_travel, right_travel, input ready);
  modport sink (input valid, left_stick, right_stick, match_enable, stop_now,
                left_travel, right_travel, output ready);
endinterface

interface tdrs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tdrs_pkg::DRIVE_W-1:0]  left_drive;
  logic signed [tdrs_pkg::DRIVE_W-1:0]  right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink (input valid, left_drive, right_drive, output ready);
endinterface
`default_nettype wire

@@ rtl/tdrs_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdrs_cfg
// APB register file; also registers the curve segment offsets.
// ----------------------------------------------------------------------------
module tdrs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tdrs_pkg::CFG_AW-1:0]         paddr,
  input  logic [tdrs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tdrs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [tdrs_pkg::CFG_W-1:0]          match_tolerance,
  output logic [tdrs_pkg::CFG_W-1:0]          ramp_step,
  output logic [tdrs_pkg::CFG_W-1:0]          follow_gain,
  output tdrs_pkg::curve_cfg_t                curve
);

  logic [tdrs_pkg::CFG_W-1:0]   match_tolerance_r;
  logic [tdrs_pkg::CFG_W-1:0]   ramp_step_r;
  logic [tdrs_pkg::CFG_W-1:0]   follow_gain_r;
  logic [tdrs_pkg::CFG_W-1:0]   knee_low_r;
  logic [tdrs_pkg::CFG_W-1:0]   knee_high_r;
  logic [tdrs_pkg::SLOPE_W-1:0] slope_low_r;
  logic [tdrs_pkg::SLOPE_W-1:0] slope_mid_r;
  logic [tdrs_pkg::SLOPE_W-1:0] slope_high_r;

  logic [tdrs_pkg::BASEA_W-1:0]        base_a_r;
  logic signed [tdrs_pkg::BASEB_W-1:0] base_b_r;
  logic signed [tdrs_pkg::SLOPE_W-1:0] knee_span;
  logic signed [tdrs_pkg::SLOPE_W:0]   slope_mid_s;

  tdrs_pkg::cfg_idx_t idx;
  logic               wr_en;

  assign idx    = tdrs_pkg::cfg_idx_t'(paddr[tdrs_pkg::CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_tolerance_r <= tdrs_pkg::MATCH_TOL_RST;
      ramp_step_r       <= tdrs_pkg::RAMP_STEP_RST;
      follow_gain_r     <= tdrs_pkg::FOLLOW_GAIN_RST;
      knee_low_r        <= tdrs_pkg::KNEE_LOW_RST;
      knee_high_r       <= tdrs_pkg::KNEE_HIGH_RST;
      slope_low_r       <= tdrs_pkg::SLOPE_LOW_RST;
      slope_mid_r       <= tdrs_pkg::SLOPE_MID_RST;
      slope_high_r      <= tdrs_pkg::SLOPE_HIGH_RST;
    end else if (wr_en) begin
      unique case (idx)
        tdrs_pkg::REG_MATCH_TOL:   match_tolerance_r <= pwdata[tdrs_pkg::CFG_W-1:0];
        tdrs_pkg::REG_RAMP_STEP:   ramp_step_r       <= pwdata[tdrs_pkg::CFG_W-1:0];
        tdrs_pkg::REG_FOLLOW_GAIN: follow_gain_r     <= pwdata[tdrs_pkg::CFG_W-1:0];
        tdrs_pkg::REG_KNEE_LOW:    knee_low_r        <= pwdata[tdrs_pkg::CFG_W-1:0];
        tdrs_pkg::REG_KNEE_HIGH:   knee_high_r       <= pwdata[tdrs_pkg::CFG_W-1:0];
        tdrs_pkg::REG_SLOPE_LOW:   slope_low_r       <= pwdata[tdrs_pkg::SLOPE_W-1:0];
        tdrs_pkg::REG_SLOPE_MID:   slope_mid_r       <= pwdata[tdrs_pkg::SLOPE_W-1:0];
        tdrs_pkg::REG_SLOPE_HIGH:  slope_high_r      <= pwdata[tdrs_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      tdrs_pkg::REG_MATCH_TOL:   prdata = {17'd0, match_tolerance_r};
      tdrs_pkg::REG_RAMP_STEP:   prdata = {17'd0, ramp_step_r};
      tdrs_pkg::REG_FOLLOW_GAIN: prdata = {17'd0, follow_gain_r};
      tdrs_pkg::REG_KNEE_LOW:    prdata = {17'd0, knee_low_r};
      tdrs_pkg::REG_KNEE_HIGH:   prdata = {17'd0, knee_high_r};
      tdrs_pkg::REG_SLOPE_LOW:   prdata = {16'd0, slope_low_r};
      tdrs_pkg::REG_SLOPE_MID:   prdata = {16'd0, slope_mid_r};
      tdrs_pkg::REG_SLOPE_HIGH:  prdata = {16'd0, slope_high_r};
      default:                   prdata = '0;
    endcase
  end

  // segment offsets, registered from the knee and slope registers
  assign knee_span   = $signed({1'b0, knee_high_r}) - $signed({1'b0, knee_low_r});
  assign slope_mid_s = $signed({1'b0, slope_mid_r});

  always_ff @(posedge clk) begin
    base_a_r <= knee_low_r * slope_low_r;
    base_b_r <= knee_span * slope_mid_s;
  end

  assign match_tolerance  = match_tolerance_r;
  assign ramp_step        = ramp_step_r;
  assign follow_gain      = follow_gain_r;
  assign curve.knee_low   = knee_low_r;
  assign curve.knee_high  = knee_high_r;
  assign curve.slope_low  = slope_low_r;
  assign curve.slope_mid  = slope_mid_r;
  assign curve.slope_high = slope_high_r;
  assign curve.base_a     = base_a_r;
  assign curve.base_b     = base_b_r;

endmodule
`default_nettype wire

@@ rtl/tdrs_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdrs_lane
// One drive side: ramp register, then a four-stage piecewise curve.
// ----------------------------------------------------------------------------
module tdrs_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tdrs_pkg::fe_ctl_t                     ctl,
  input  logic signed [tdrs_pkg::TGT_W-1:0]     target,
  input  logic [tdrs_pkg::CFG_W-1:0]            ramp_step,
  input  tdrs_pkg::curve_cfg_t                  cc,
  output logic signed [tdrs_pkg::CURVE_W-1:0]   drive
);

  localparam int RX_W = tdrs_pkg::TGT_W + 1;
  localparam logic signed [RX_W-1:0] RMAX = RX_W'(tdrs_pkg::RAMP_LIMIT);
  localparam logic signed [RX_W-1:0] RMIN = -RMAX;

  logic signed [tdrs_pkg::RAMP_W-1:0]  ramp_r;
  logic signed [tdrs_pkg::RAMP_W-1:0]  ramp_nxt;
  logic signed [tdrs_pkg::RAMP_W-1:0]  ramp_sat;
  logic signed [RX_W-1:0]              tgt_x;
  logic signed [RX_W-1:0]              ramp_x;
  logic signed [RX_W-1:0]              step_x;
  logic signed [RX_W-1:0]              stepped;

  logic signed [tdrs_pkg::RAMP_W-1:0]  x1_r;
  logic [tdrs_pkg::RAMP_W-1:0]         mag_full;
  logic [tdrs_pkg::MAG_W-1:0]          mag;
  logic                                seg_lo;
  logic                                seg_mid;
  logic [tdrs_pkg::MAG_W-1:0]          delta;
  logic [tdrs_pkg::SLOPE_W-1:0]        slope;
  logic signed [tdrs_pkg::BASE_W-1:0]  base_ab;
  logic signed [tdrs_pkg::BASE_W-1:0]  base;

  logic [tdrs_pkg::PROD_W-1:0]         prod2_r;
  logic signed [tdrs_pkg::BASE_W-1:0]  base2_r;
  logic                                neg2_r;
  logic                                zero2_r;

  logic signed [tdrs_pkg::Y_W-1:0]     y3_r;
  logic                                neg3_r;
  logic                                zero3_r;
  logic signed [tdrs_pkg::Y_W-1:0]     rnd;
  logic signed [tdrs_pkg::Y_W-1:0]     ysum;
  logic signed [tdrs_pkg::CURVE_W-1:0] rx;
  logic signed [tdrs_pkg::CURVE_W-1:0] drive_nxt;
  logic signed [tdrs_pkg::CURVE_W-1:0] drive_r;

  // ramp step, saturate, stop
  assign tgt_x  = $signed({target[tdrs_pkg::TGT_W-1], target});
  assign ramp_x = $signed({{2{ramp_r[tdrs_pkg::RAMP_W-1]}}, ramp_r});
  assign step_x = $signed({3'd0, ramp_step});

  always_comb begin
    stepped = (tgt_x > ramp_x) ? ramp_x + step_x : ramp_x - step_x;
    if (stepped > RMAX) begin
      ramp_sat = RMAX[tdrs_pkg::RAMP_W-1:0];
    end else if (stepped < RMIN) begin
      ramp_sat = RMIN[tdrs_pkg::RAMP_W-1:0];
    end else begin
      ramp_sat = stepped[tdrs_pkg::RAMP_W-1:0];
    end
    ramp_nxt = ctl.stop ? '0 : ramp_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= '0;
    end else if (ctl.acc) begin
      ramp_r <= ramp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= ramp_nxt;
  end

  // segment select and multiply
  assign mag_full = x1_r[tdrs_pkg::RAMP_W-1] ? -x1_r : x1_r;
  assign mag      = mag_full[tdrs_pkg::MAG_W-1:0];
  assign seg_lo   = mag < cc.knee_low;
  assign seg_mid  = mag < cc.knee_high;
  assign base_ab  = $signed({3'd0, cc.base_a}) +
                    $signed({cc.base_b[tdrs_pkg::BASEB_W-1], cc.base_b});

  always_comb begin
    if (seg_lo) begin
      delta = mag;
      slope = cc.slope_low;
      base  = '0;
    end else if (seg_mid) begin
      delta = mag - cc.knee_low;
      slope = cc.slope_mid;
      base  = $signed({3'd0, cc.base_a});
    end else begin
      delta = mag - cc.knee_high;
      slope = cc.slope_high;
      base  = base_ab;
    end
  end

  always_ff @(posedge clk) begin
    prod2_r <= delta * slope;
    base2_r <= base;
    neg2_r  <= x1_r[tdrs_pkg::RAMP_W-1];
    zero2_r <= (x1_r == '0);
  end

  // accumulate
  always_ff @(posedge clk) begin
    y3_r    <= $signed({5'd0, prod2_r}) + $signed({{2{base2_r[tdrs_pkg::BASE_W-1]}}, base2_r});
    neg3_r  <= neg2_r;
    zero3_r <= zero2_r;
  end

  // round half away from zero to Q2.14, then take the ramp sign
  assign rnd  = y3_r[tdrs_pkg::Y_W-1] ? tdrs_pkg::Y_W'(2047) : tdrs_pkg::Y_W'(2048);
  assign ysum = y3_r + rnd;
  assign rx   = $signed({ysum[tdrs_pkg::Y_W-1], ysum[tdrs_pkg::Y_W-1:12]});

  always_comb begin
    if (zero3_r) begin
      drive_nxt = '0;
    end else if (neg3_r) begin
      drive_nxt = -rx;
    end else begin
      drive_nxt = rx;
    end
  end

  always_ff @(posedge clk) begin
    drive_r <= drive_nxt;
  end

  assign drive = drive_r;

endmodule
`default_nettype wire

@@ rtl/tdrs_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdrs_merge
// Travel correction, output saturation, result queue and input credit.
// ----------------------------------------------------------------------------
module tdrs_merge #(
  parameter int unsigned FIFO_DEPTH = tdrs_pkg::FIFO_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tdrs_pkg::fe_ctl_t                     ctl,
  input  logic signed [tdrs_pkg::TRAVEL_W-1:0]  left_travel,
  input  logic signed [tdrs_pkg::TRAVEL_W-1:0]  right_travel,
  input  logic [tdrs_pkg::CFG_W-1:0]            follow_gain,
  input  logic signed [tdrs_pkg::CURVE_W-1:0]   left_curve,
  input  logic signed [tdrs_pkg::CURVE_W-1:0]   right_curve,
  output logic                                  in_ready,
  tdrs_out_if.source                            out_ch
);

  localparam int AW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0]   LAST_PTR = AW'(FIFO_DEPTH - 1);
  localparam logic [CNTW-1:0] DEPTH_C  = CNTW'(FIFO_DEPTH);
  localparam int SUM_W = tdrs_pkg::CORR_W + 1;
  localparam logic signed [tdrs_pkg::CPROD_W-1:0] PMAX =
    tdrs_pkg::CPROD_W'(tdrs_pkg::CORR_LIMIT);
  localparam logic signed [tdrs_pkg::CPROD_W-1:0] PMIN = -PMAX;
  localparam logic signed [SUM_W-1:0] DMAX = SUM_W'(tdrs_pkg::DRIVE_LIMIT);
  localparam logic signed [SUM_W-1:0] DMIN = -DMAX;

  logic                                     v1_r, v2_r, v3_r, v4_r;
  logic signed [tdrs_pkg::DIFF_W-1:0]       d1_r;
  logic                                     apply1_r, lpos1_r, stop1_r;
  logic signed [tdrs_pkg::CPROD_W-1:0]      p2_r;
  logic                                     apply2_r, lsel2_r, stop2_r;
  logic signed [tdrs_pkg::CORR_W-1:0]       pc3_r, pc4_r;
  logic                                     apply3_r, lsel3_r, stop3_r;
  logic                                     apply4_r, lsel4_r, stop4_r;
  logic signed [tdrs_pkg::CORR_W-1:0]       pc_nxt;
  logic signed [tdrs_pkg::SLOPE_W-1:0]      gain_s;
  logic                                     dpos, dneg;

  logic signed [SUM_W-1:0]                  lcurve_x, rcurve_x, pc_x;
  logic signed [SUM_W-1:0]                  lsum, rsum;
  tdrs_pkg::drive_pair_t                    item;

  tdrs_pkg::drive_pair_t                    mem [FIFO_DEPTH];
  logic [AW-1:0]                            wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]                          fcnt_r, fcnt_nxt;
  logic [CNTW-1:0]                          ocnt_r, ocnt_nxt;
  logic                                     ready_r;
  logic                                     push, pop;
  logic                                     load_head, mem_rd, mem_wr;
  logic                                     head_vld_r;
  tdrs_pkg::drive_pair_t                    head_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= ctl.acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // travel difference
  always_ff @(posedge clk) begin
    d1_r     <= $signed({left_travel[tdrs_pkg::TRAVEL_W-1], left_travel}) -
                $signed({right_travel[tdrs_pkg::TRAVEL_W-1], right_travel});
    apply1_r <= ctl.apply;
    lpos1_r  <= ctl.lpos;
    stop1_r  <= ctl.stop;
  end

  // correction product; side picked by stick sign and travel sign
  assign gain_s = $signed({1'b0, follow_gain});
  assign dneg   = d1_r[tdrs_pkg::DIFF_W-1];
  assign dpos   = !dneg && (d1_r != '0);

  always_ff @(posedge clk) begin
    p2_r     <= d1_r * gain_s;
    apply2_r <= apply1_r;
    lsel2_r  <= lpos1_r ? dpos : dneg;
    stop2_r  <= stop1_r;
  end

  // clamp far beyond the drive range so the final add stays narrow
  always_comb begin
    if (p2_r > PMAX) begin
      pc_nxt = PMAX[tdrs_pkg::CORR_W-1:0];
    end else if (p2_r < PMIN) begin
      pc_nxt = PMIN[tdrs_pkg::CORR_W-1:0];
    end else begin
      pc_nxt = p2_r[tdrs_pkg::CORR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pc3_r    <= pc_nxt;
    apply3_r <= apply2_r;
    lsel3_r  <= lsel2_r;
    stop3_r  <= stop2_r;
    pc4_r    <= pc3_r;
    apply4_r <= apply3_r;
    lsel4_r  <= lsel3_r;
    stop4_r  <= stop3_r;
  end

  // apply, saturate, and zero on stop
  assign lcurve_x = $signed({{4{left_curve[tdrs_pkg::CURVE_W-1]}}, left_curve});
  assign rcurve_x = $signed({{4{right_curve[tdrs_pkg::CURVE_W-1]}}, right_curve});
  assign pc_x     = $signed({pc4_r[tdrs_pkg::CORR_W-1], pc4_r});

  always_comb begin
    lsum = (apply4_r && lsel4_r)  ? lcurve_x - pc_x : lcurve_x;
    rsum = (apply4_r && !lsel4_r) ? rcurve_x + pc_x : rcurve_x;

    if (lsum > DMAX) begin
      item.left = DMAX[tdrs_pkg::DRIVE_W-1:0];
    end else if (lsum < DMIN) begin
      item.left = DMIN[tdrs_pkg::DRIVE_W-1:0];
    end else begin
      item.left = lsum[tdrs_pkg::DRIVE_W-1:0];
    end

    if (rsum > DMAX) begin
      item.right = DMAX[tdrs_pkg::DRIVE_W-1:0];
    end else if (rsum < DMIN) begin
      item.right = DMIN[tdrs_pkg::DRIVE_W-1:0];
    end else begin
      item.right = rsum[tdrs_pkg::DRIVE_W-1:0];
    end

    if (stop4_r) begin
      item = '0;
    end
  end

  // result queue: head register in front of the array, empty array bypassed
  assign push      = v4_r;
  assign pop       = head_vld_r & out_ch.ready;
  assign load_head = !head_vld_r | pop;
  assign mem_rd    = load_head & (fcnt_r != '0);
  assign mem_wr    = push & !(load_head & (fcnt_r == '0));

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      head_r <= mem[rd_ptr_r];
    end else if (load_head && push) begin
      head_r <= item;
    end
  end

  assign fcnt_nxt = fcnt_r + CNTW'(mem_wr) - CNTW'(mem_rd);
  assign ocnt_nxt = ocnt_r + CNTW'(ctl.acc) - CNTW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fcnt_r     <= '0;
      ocnt_r     <= '0;
      ready_r    <= 1'b0;
      head_vld_r <= 1'b0;
    end else begin
      if (mem_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (mem_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (load_head) begin
        head_vld_r <= mem_rd | push;
      end
      fcnt_r  <= fcnt_nxt;
      ocnt_r  <= ocnt_nxt;
      ready_r <= ocnt_nxt < DEPTH_C;
    end
  end

  assign in_ready           = ready_r;
  assign out_ch.valid       = head_vld_r;
  assign out_ch.left_drive  = head_r.left;
  assign out_ch.right_drive = head_r.right;

endmodule
`default_nettype wire

@@ rtl/tank_drive_ramp_shaper_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tank_drive_ramp_shaper_unit
// Throughput: one beat per cycle; at most FIFO_DEPTH beats outstanding, set
//   by the result queue, so in_ch.ready drops only while FIFO_DEPTH beats are outstanding.
// Reset (rst_n low, synchronous): ramps to zero, registers to defaults,
//   pipeline and result queue emptied, in_ch.ready low for one cycle after.
// ----------------------------------------------------------------------------
module tank_drive_ramp_shaper_unit #(
  parameter int unsigned FIFO_DEPTH = tdrs_pkg::FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tdrs_in_if.sink                           in_ch,
  tdrs_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tdrs_pkg::CFG_AW-1:0]       paddr,
  input  logic [tdrs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tdrs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int D_W = tdrs_pkg::TGT_W + 1;

  logic [tdrs_pkg::CFG_W-1:0]           match_tolerance;
  logic [tdrs_pkg::CFG_W-1:0]           ramp_step;
  logic [tdrs_pkg::CFG_W-1:0]           follow_gain;
  tdrs_pkg::curve_cfg_t                 curve;

  logic signed [tdrs_pkg::TGT_W-1:0]    lt, rt, lt_eff, rt_eff;
  logic                                 lpos, lneg, rpos, rneg, same_sign;
  logic signed [D_W-1:0]                diff, adiff;
  logic                                 dpos, dneg, close;
  logic                                 in_ready;
  tdrs_pkg::fe_ctl_t                    ctl;
  logic signed [tdrs_pkg::CURVE_W-1:0]  left_curve, right_curve;

  tdrs_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .match_tolerance (match_tolerance),
    .ramp_step       (ramp_step),
    .follow_gain     (follow_gain),
    .curve           (curve)
  );

  // negate sticks and pull matching commands together
  assign lt = -$signed({in_ch.left_stick[tdrs_pkg::STICK_W-1], in_ch.left_stick});
  assign rt = -$signed({in_ch.right_stick[tdrs_pkg::STICK_W-1], in_ch.right_stick});

  assign lneg      = lt[tdrs_pkg::TGT_W-1];
  assign lpos      = !lneg && (lt != '0);
  assign rneg      = rt[tdrs_pkg::TGT_W-1];
  assign rpos      = !rneg && (rt != '0);
  assign same_sign = (lpos == rpos) && (lneg == rneg);

  assign diff  = $signed({lt[tdrs_pkg::TGT_W-1], lt}) - $signed({rt[tdrs_pkg::TGT_W-1], rt});
  assign dneg  = diff[D_W-1];
  assign dpos  = !dneg && (diff != '0);
  assign adiff = dneg ? -diff : diff;
  assign close = (adiff <= $signed({3'd0, match_tolerance}));

  always_comb begin
    lt_eff = lt;
    rt_eff = rt;
    if (close && same_sign) begin
      if ((lpos == dpos) && (lneg == dneg)) begin
        rt_eff = lt;
      end else begin
        lt_eff = rt;
      end
    end
  end

  assign ctl.acc   = in_ch.valid & in_ready;
  assign ctl.stop  = in_ch.stop_now;
  assign ctl.apply = same_sign & in_ch.match_enable;
  assign ctl.lpos  = lpos;

  tdrs_lane u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .target    (lt_eff),
    .ramp_step (ramp_step),
    .cc        (curve),
    .drive     (left_curve)
  );

  tdrs_lane u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .target    (rt_eff),
    .ramp_step (ramp_step),
    .cc        (curve),
    .drive     (right_curve)
  );

  tdrs_merge #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .left_travel  (in_ch.left_travel),
    .right_travel (in_ch.right_travel),
    .follow_gain  (follow_gain),
    .left_curve   (left_curve),
    .right_curve  (right_curve),
    .in_ready     (in_ready),
    .out_ch       (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

@@ rtl/tdrs_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdrs_checker
// Port-level checks on the shaper's channels, bound to the top level.
// ----------------------------------------------------------------------------
module tdrs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tdrs_pkg::DRIVE_W-1:0] out_left_drive,
  input logic signed [tdrs_pkg::DRIVE_W-1:0] out_right_drive
);

  localparam int LAT = 5;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_drive) &&
                                $stable(out_right_drive))
    else $error("out beat changed while stalled");

  // reset empties the result side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // a fresh result follows an accepted beat by the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, LAT))
    else $error("out beat without matching in beat");

  // input back-pressure only while results are queued
  a_ready_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !in_ready |-> out_valid)
    else $error("in ready low with nothing queued");

endmodule

bind tank_drive_ramp_shaper_unit tdrs_checker u_tdrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_left_drive  (out_ch.left_drive),
  .out_right_drive (out_ch.right_drive)
);
`default_nettype wire
